>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

>>> hw/rtl/ptg_pkg.sv
// ----------------------------------------------------------------------------
// Pixel to ground projection package
// Shared constants, register indexes and CORDIC tables.
// ----------------------------------------------------------------------------
package ptg_pkg;

	localparam int IMAGE_WIDTH  = 320;
	localparam int IMAGE_HEIGHT = 240;
	localparam int CENTER_COL   = (IMAGE_WIDTH + 1) / 2;
	localparam int CENTER_ROW   = (IMAGE_HEIGHT + 1) / 2;

	localparam int LINK_A        = 114;
	localparam int LINK_B        = 97;
	localparam int BEND_ANGLE    = 5461;
	localparam int TILT_BASE     = 49152;
	localparam int CORDIC_GAIN   = 652032874;
	localparam int CORDIC_STEPS  = 15;
	localparam int HORIZON_LIMIT = 1048576;
	localparam int MAG_MAX       = 1073741824;
	localparam int DIV_STEPS     = 31;
	localparam int DIV_INIT_REM  = 1 << (50 - DIV_STEPS);

	localparam int ANG_W  = 16;
	localparam int TRIG_W = 17;
	localparam int AT_IN_W = 18;
	localparam int CR_W   = 33;
	localparam int CZ_W   = 18;

	localparam int OUT_MAX = 32767;
	localparam int OUT_MIN = -32768;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 14;
	localparam logic [CFG_IDX_W-1:0] REG_NECK_HEIGHT      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_VERTICAL   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_HORIZONTAL = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LATERAL_OFFSET   = 8'd3;

	localparam logic [11:0] NECK_HEIGHT_RST = 12'd1872;
	localparam logic [13:0] FOCAL_V_RST     = 14'd6260;
	localparam logic [13:0] FOCAL_H_RST     = 14'd5982;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;

	localparam logic [13:0] ARC_STEP [CORDIC_STEPS] = '{
		14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
		14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1
	};

endpackage

>>> hw/rtl/ptg_sincos.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// One rotation step per stage plus a rounding and quadrant stage.
// ----------------------------------------------------------------------------
module ptg_sincos (
	input  logic                                clk,
	input  logic                                en,
	input  logic [ptg_pkg::ANG_W-1:0]           ang,
	output logic signed [ptg_pkg::TRIG_W-1:0]   cos_val,
	output logic signed [ptg_pkg::TRIG_W-1:0]   sin_val
);
	localparam int N  = ptg_pkg::CORDIC_STEPS;
	localparam int XW = ptg_pkg::CR_W;
	localparam int ZW = ptg_pkg::CZ_W;
	localparam int TW = ptg_pkg::TRIG_W;

	logic signed [XW-1:0] x_s [N];
	logic signed [XW-1:0] y_s [N];
	logic signed [ZW-1:0] z_s [N];
	logic [1:0]           q_s [N];
	logic signed [TW-1:0] cc, ss;

	function automatic logic signed [TW-1:0] to_q15(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		r = (v + XW'(16384)) >>> 15;
		if (r > XW'(32768))
			return TW'(32768);
		if (r < -XW'(32768))
			return -TW'(32768);
		return TW'(r);
	endfunction

	genvar i;
	for (i = 0; i < N; i++) begin : g_iter
		logic signed [XW-1:0] xp, yp;
		logic signed [ZW-1:0] zp;
		logic [1:0]           qp;
		if (i == 0) begin : g_first
			assign xp = XW'(ptg_pkg::CORDIC_GAIN);
			assign yp = '0;
			assign zp = ZW'({1'b0, ang[ptg_pkg::ANG_W-3:0]});
			assign qp = ang[ptg_pkg::ANG_W-1 -: 2];
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign qp = q_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zp[ZW-1]) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - ZW'(ptg_pkg::ARC_STEP[i]);
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + ZW'(ptg_pkg::ARC_STEP[i]);
				end
				q_s[i] <= qp;
			end
		end
	end

	always_comb begin
		cc = to_q15(x_s[N-1]);
		ss = to_q15(y_s[N-1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[N-1])
				ptg_pkg::QUAD_I: begin
					cos_val <= cc;
					sin_val <= ss;
				end
				ptg_pkg::QUAD_II: begin
					cos_val <= -ss;
					sin_val <= cc;
				end
				ptg_pkg::QUAD_III: begin
					cos_val <= -cc;
					sin_val <= -ss;
				end
				default: begin
					cos_val <= ss;
					sin_val <= -cc;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/ptg_atan2.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC arctangent
// Vectoring mode, one step per stage plus an output stage.
// ----------------------------------------------------------------------------
module ptg_atan2 (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [ptg_pkg::AT_IN_W-1:0]   yin,
	input  logic [13:0]                          xin,
	output logic [ptg_pkg::ANG_W-1:0]            ang
);
	localparam int N  = ptg_pkg::CORDIC_STEPS;
	localparam int XW = ptg_pkg::CR_W;
	localparam int ZW = ptg_pkg::CZ_W;

	logic signed [XW-1:0] x_s [N];
	logic signed [XW-1:0] y_s [N];
	logic signed [ZW-1:0] z_s [N];
	logic                 zero_s [N];

	genvar i;
	for (i = 0; i < N; i++) begin : g_iter
		logic signed [XW-1:0] xp, yp;
		logic signed [ZW-1:0] zp;
		logic                 zf;
		logic                 pos;
		if (i == 0) begin : g_first
			assign xp = XW'($signed({1'b0, xin})) <<< 12;
			assign yp = XW'(yin) <<< 12;
			assign zp = '0;
			assign zf = (yin == '0);
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign zf = zero_s[i-1];
		end
		assign pos = !yp[XW-1] && (yp != '0);
		always_ff @(posedge clk) begin
			if (en) begin
				if (pos) begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + ZW'(ptg_pkg::ARC_STEP[i]);
				end else begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - ZW'(ptg_pkg::ARC_STEP[i]);
				end
				zero_s[i] <= zf;
			end
		end
	end

	// a zero offset gives angle zero whatever the focal length
	always_ff @(posedge clk) begin
		if (en) begin
			ang <= zero_s[N-1] ? '0 : z_s[N-1][ptg_pkg::ANG_W-1:0];
		end
	end

endmodule

>>> hw/rtl/pixel_to_ground_projection_core.sv
// ----------------------------------------------------------------------------
// Pixel to ground projection core
// Casts a pixel ray through the neck and camera model onto the ground plane.
// ----------------------------------------------------------------------------
// One item per clock while out_ready does not hold the pipeline. The depth is
// set by the CORDIC units (16 stages each, two in series) and the reciprocal
// divider, which resolves one quotient bit per stage over 31 stages. The
// whole pipeline holds while a result waits on out_ready; in_ready drops at
// the same time. Configuration writes are always taken and must only be made
// while no item is in flight.
`include "assert_macros.svh"

module pixel_to_ground_projection_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ptg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ptg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [8:0]                         pixel_x,
	input  logic [7:0]                         pixel_y,
	input  logic [11:0]                        pan_position,
	input  logic [11:0]                        tilt_position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [15:0]                 ground_x,
	output logic signed [15:0]                 ground_y,
	output logic                               saturated
);
	localparam int AW = ptg_pkg::ANG_W;
	localparam int TW = ptg_pkg::TRIG_W;
	localparam int IW = ptg_pkg::AT_IN_W;
	localparam int LAT = 74;

	// configuration
	logic [11:0]        neck_height_q;
	logic [13:0]        focal_vertical_q;
	logic [13:0]        focal_horizontal_q;
	logic signed [11:0] lateral_offset_q;

	logic en;
	logic [LAT:1] v_s;

	// input side
	logic [AW-1:0]        ta, tb;
	logic signed [IW-1:0] py16, px16;
	logic [AW-1:0]        tb_s [1:16];
	logic [11:0]          pan_s [1:53];

	// stage 16 results
	logic signed [TW-1:0] ca, sa, cb, sb;
	logic [AW-1:0]        ty, tx;

	// stage 17
	logic signed [24:0]   hsum, lsum;
	logic signed [13:0]   h_next;
	logic [AW-1:0]        tr_s17, tx_s17;
	logic signed [13:0]   h_s [17:33];
	logic signed [24:0]   lca_s [17:68];

	// stage 33 results
	logic signed [TW-1:0] cr, sr, cx, sx;

	// stages 34, 35
	logic signed [31:0]   d_s34;
	logic signed [28:0]   hs_s34, hx_s34;
	logic signed [TW-1:0] cx_s34;
	logic signed [31:0]   d_abs;
	logic                 near;
	logic [30:0]          mag_s35;
	logic                 neg_s35, flag_s35;
	logic signed [43:0]   hsc_s35;
	logic signed [28:0]   hx_s35;

	// divider
	logic [30:0]          div_r_s [36:66];
	logic [30:0]          div_q_s [36:66];
	logic [30:0]          div_m_s [36:66];
	logic signed [28:0]   a_s [36:66];
	logic signed [28:0]   hxd_s [36:66];
	logic                 neg_s [36:66];
	logic                 flag_s [36:66];

	// back end
	logic signed [31:0]   inv_s67;
	logic signed [28:0]   a_s67, hx_s67;
	logic signed [60:0]   ma_s68, mx_s68;
	logic signed [43:0]   ly_s69, lx_s69;
	logic signed [TW-1:0] cp, sp;
	logic signed [21:0]   lx_hi, ly_hi;
	logic signed [22:0]   lx_lo, ly_lo;
	logic signed [39:0]   xc_hi_s70, xc_lo_s70, xs_hi_s70, xs_lo_s70;
	logic signed [39:0]   yc_hi_s70, yc_lo_s70, ys_hi_s70, ys_lo_s70;
	logic signed [63:0]   xc_s71, xs_s71, yc_s71, ys_s71;
	logic signed [63:0]   vx_s72, vy_s72;
	logic signed [28:0]   gx_s73, gy_s73;
	logic                 flag_s67, flag_s68, flag_s69, flag_s70, flag_s71;
	logic                 flag_s72, flag_s73;
	logic signed [15:0]   gx_s74, gy_s74;
	logic                 sat_s74;
	logic signed [15:0]   gx_clip, gy_clip;
	logic                 clip_x, clip_y;

	function automatic logic signed [28:0] trunc35(input logic signed [63:0] v);
		logic signed [63:0] b;
		b = v + (v[63] ? 64'sd34359738367 : 64'sd0);
		return 29'(b >>> 35);
	endfunction

	// ---------------- configuration port ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neck_height_q      <= ptg_pkg::NECK_HEIGHT_RST;
			focal_vertical_q   <= ptg_pkg::FOCAL_V_RST;
			focal_horizontal_q <= ptg_pkg::FOCAL_H_RST;
			lateral_offset_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ptg_pkg::REG_NECK_HEIGHT:      neck_height_q <= cfg_data[11:0];
				ptg_pkg::REG_FOCAL_VERTICAL:   focal_vertical_q <= cfg_data[13:0];
				ptg_pkg::REG_FOCAL_HORIZONTAL: focal_horizontal_q <= cfg_data[13:0];
				ptg_pkg::REG_LATERAL_OFFSET:   lateral_offset_q <= $signed(cfg_data[11:0]);
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	assign en        = !v_s[LAT] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[LAT-1:1], in_valid};
		end
	end

	// ---------------- front end ----------------
	always_comb begin
		ta   = AW'(ptg_pkg::TILT_BASE) - {tilt_position, 4'b0000};
		tb   = ta - AW'(ptg_pkg::BEND_ANGLE);
		py16 = IW'((IW'(ptg_pkg::CENTER_ROW) - IW'(pixel_y)) << 4);
		px16 = IW'((IW'(pixel_x) - IW'(ptg_pkg::CENTER_COL)) << 4);
	end

	ptg_sincos u_sc_a (.clk(clk), .en(en), .ang(ta), .cos_val(ca), .sin_val(sa));
	ptg_sincos u_sc_b (.clk(clk), .en(en), .ang(tb), .cos_val(cb), .sin_val(sb));
	ptg_atan2  u_at_y (.clk(clk), .en(en), .yin(py16), .xin(focal_vertical_q), .ang(ty));
	ptg_atan2  u_at_x (.clk(clk), .en(en), .yin(px16), .xin(focal_horizontal_q), .ang(tx));

	always_ff @(posedge clk) begin
		if (en) begin
			tb_s[1]  <= tb;
			pan_s[1] <= pan_position;
			for (int k = 2; k <= 16; k++)
				tb_s[k] <= tb_s[k-1];
			for (int k = 2; k <= 53; k++)
				pan_s[k] <= pan_s[k-1];
		end
	end

	// ---------------- stage 17: neck geometry, ray angle ----------------
	always_comb begin
		hsum   = 25'(ptg_pkg::LINK_A) * 25'(sa) + 25'(ptg_pkg::LINK_B) * 25'(sb)
			+ 25'sd16384;
		lsum   = 25'(ptg_pkg::LINK_A) * 25'(ca) + 25'(ptg_pkg::LINK_B) * 25'(cb);
		h_next = 14'($signed({2'b00, neck_height_q})) + 14'(hsum >>> 15);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tr_s17    <= ty + tb_s[16];
			tx_s17    <= tx;
			h_s[17]   <= h_next;
			lca_s[17] <= lsum <<< 1;
			for (int k = 18; k <= 33; k++)
				h_s[k] <= h_s[k-1];
			for (int k = 18; k <= 68; k++)
				lca_s[k] <= lca_s[k-1];
		end
	end

	ptg_sincos u_sc_r (.clk(clk), .en(en), .ang(tr_s17), .cos_val(cr), .sin_val(sr));
	ptg_sincos u_sc_x (.clk(clk), .en(en), .ang(tx_s17), .cos_val(cx), .sin_val(sx));

	// ---------------- stages 34, 35: denominator and horizon clamp ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			d_s34  <= 32'(cr) * 32'(cx);
			hs_s34 <= 29'(31'(h_s[33]) * 31'(sr));
			hx_s34 <= 29'(31'(h_s[33]) * 31'(sx));
			cx_s34 <= cx;
		end
	end

	always_comb begin
		near  = (d_s34 < 32'(ptg_pkg::HORIZON_LIMIT)) && (d_s34 > -32'(ptg_pkg::HORIZON_LIMIT));
		d_abs = d_s34[31] ? -d_s34 : d_s34;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s35  <= near ? 31'(ptg_pkg::HORIZON_LIMIT) : 31'(d_abs);
			neg_s35  <= d_s34[31];
			flag_s35 <= near;
			hsc_s35  <= 44'(hs_s34) * 44'(cx_s34);
			hx_s35   <= hx_s34;
		end
	end

	// ---------------- reciprocal: 2^50 / mag, one bit per stage ----------------
	genvar g;
	for (g = 0; g < ptg_pkg::DIV_STEPS; g++) begin : g_div
		logic [30:0] r_prev, q_prev, m_prev;
		logic [31:0] sh;
		logic        ge;
		if (g == 0) begin : g_first
			assign r_prev = 31'(ptg_pkg::DIV_INIT_REM);
			assign q_prev = '0;
			assign m_prev = mag_s35;
		end else begin : g_next
			assign r_prev = div_r_s[35+g];
			assign q_prev = div_q_s[35+g];
			assign m_prev = div_m_s[35+g];
		end
		assign sh = {r_prev, 1'b0};
		assign ge = sh >= {1'b0, m_prev};
		always_ff @(posedge clk) begin
			if (en) begin
				div_r_s[36+g] <= ge ? 31'(sh - {1'b0, m_prev}) : sh[30:0];
				div_q_s[36+g] <= {q_prev[29:0], ge};
				div_m_s[36+g] <= m_prev;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[36]    <= hsc_s35[43:15];
			hxd_s[36]  <= hx_s35;
			neg_s[36]  <= neg_s35;
			flag_s[36] <= flag_s35;
			for (int k = 37; k <= 66; k++) begin
				a_s[k]    <= a_s[k-1];
				hxd_s[k]  <= hxd_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				flag_s[k] <= flag_s[k-1];
			end
		end
	end

	// ---------------- stages 67 to 69: ground distances ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s67  <= neg_s[66] ? -32'($signed({1'b0, div_q_s[66]}))
				: 32'($signed({1'b0, div_q_s[66]}));
			a_s67    <= a_s[66];
			hx_s67   <= hxd_s[66];
			flag_s67 <= flag_s[66];

			ma_s68   <= 61'(a_s67) * 61'(inv_s67);
			mx_s68   <= 61'(hx_s67) * 61'(inv_s67);
			flag_s68 <= flag_s67;

			ly_s69   <= 44'(lca_s[68]) + 44'(ma_s68 >>> 19);
			lx_s69   <= 44'(mx_s68 >>> 19) + (44'(lateral_offset_q) <<< 16);
			flag_s69 <= flag_s68;
		end
	end

	ptg_sincos u_sc_p (
		.clk(clk), .en(en), .ang({pan_s[53], 4'b0000}), .cos_val(cp), .sin_val(sp)
	);

	// ---------------- stages 70 to 74: pan rotation and output ----------------
	// distances are split so each multiplier stays narrow
	always_comb begin
		lx_hi = $signed(lx_s69[43:22]);
		lx_lo = $signed({1'b0, lx_s69[21:0]});
		ly_hi = $signed(ly_s69[43:22]);
		ly_lo = $signed({1'b0, ly_s69[21:0]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xc_hi_s70 <= 40'(lx_hi) * 40'(cp);
			xc_lo_s70 <= 40'(lx_lo) * 40'(cp);
			xs_hi_s70 <= 40'(lx_hi) * 40'(sp);
			xs_lo_s70 <= 40'(lx_lo) * 40'(sp);
			yc_hi_s70 <= 40'(ly_hi) * 40'(cp);
			yc_lo_s70 <= 40'(ly_lo) * 40'(cp);
			ys_hi_s70 <= 40'(ly_hi) * 40'(sp);
			ys_lo_s70 <= 40'(ly_lo) * 40'(sp);
			flag_s70  <= flag_s69;

			xc_s71   <= (64'(xc_hi_s70) <<< 22) + 64'(xc_lo_s70);
			xs_s71   <= (64'(xs_hi_s70) <<< 22) + 64'(xs_lo_s70);
			yc_s71   <= (64'(yc_hi_s70) <<< 22) + 64'(yc_lo_s70);
			ys_s71   <= (64'(ys_hi_s70) <<< 22) + 64'(ys_lo_s70);
			flag_s71 <= flag_s70;

			vx_s72   <= ys_s71 - xc_s71;
			vy_s72   <= -(xs_s71 + yc_s71);
			flag_s72 <= flag_s71;

			gx_s73   <= trunc35(vx_s72);
			gy_s73   <= trunc35(vy_s72);
			flag_s73 <= flag_s72;
		end
	end

	always_comb begin
		clip_x  = 1'b1;
		clip_y  = 1'b1;
		if (gx_s73 > 29'(ptg_pkg::OUT_MAX))
			gx_clip = 16'(ptg_pkg::OUT_MAX);
		else if (gx_s73 < 29'(ptg_pkg::OUT_MIN))
			gx_clip = 16'(ptg_pkg::OUT_MIN);
		else begin
			gx_clip = gx_s73[15:0];
			clip_x  = 1'b0;
		end
		if (gy_s73 > 29'(ptg_pkg::OUT_MAX))
			gy_clip = 16'(ptg_pkg::OUT_MAX);
		else if (gy_s73 < 29'(ptg_pkg::OUT_MIN))
			gy_clip = 16'(ptg_pkg::OUT_MIN);
		else begin
			gy_clip = gy_s73[15:0];
			clip_y  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s74  <= gx_clip;
			gy_s74  <= gy_clip;
			sat_s74 <= flag_s73 | clip_x | clip_y;
		end
	end

	assign ground_x  = gx_s74;
	assign ground_y  = gy_s74;
	assign saturated = sat_s74;

	// ---------------- assertions ----------------
	`ASSERT_IMPLIES(a_mag_range, v_s[35], (mag_s35 >= 31'(ptg_pkg::HORIZON_LIMIT)) && (mag_s35 <= 31'(ptg_pkg::MAG_MAX)))
	`ASSERT_IMPLIES(a_div_rem, v_s[66], div_r_s[66] < div_m_s[66])
	`ASSERT_IMPLIES(a_inv_range, v_s[66], (div_q_s[66] >= 31'(ptg_pkg::HORIZON_LIMIT)) && (div_q_s[66] <= 31'(ptg_pkg::MAG_MAX)))

endmodule
